// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker of the drive command sequencer.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at each rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/dcs_pkg.sv -----
// Types, codes and default register values for the drive command sequencer.
// No dependencies.
`timescale 1ns / 1ps

package dcs_pkg;

    localparam int PWM_W  = 10;
    localparam int CMD_W  = 4;
    localparam int HOLD_W = 5;
    localparam int MODE_W = 3;
    localparam int CFG_W  = 3;

    typedef logic [PWM_W-1:0]  pwm_t;
    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [HOLD_W-1:0] hold_t;
    typedef logic [MODE_W-1:0] mode_code_t;
    typedef logic [CFG_W-1:0]  cfg_index_t;

    localparam cmd_t CMD_NONE   = 4'd0;
    localparam cmd_t CMD_KEEP   = 4'd1;
    localparam cmd_t CMD_STOP   = 4'd2;
    localparam cmd_t CMD_RLANE  = 4'd3;
    localparam cmd_t CMD_LLANE  = 4'd4;
    localparam cmd_t CMD_TRIGHT = 4'd5;
    localparam cmd_t CMD_TLEFT  = 4'd6;
    localparam cmd_t CMD_KLEFT  = 4'd7;
    localparam cmd_t CMD_KRIGHT = 4'd8;

    localparam mode_code_t MODE_CODE_READY = 3'd0;
    localparam mode_code_t MODE_CODE_KEEP  = 3'd1;
    localparam mode_code_t MODE_CODE_STOP  = 3'd2;
    localparam mode_code_t MODE_CODE_LLANE = 3'd3;
    localparam mode_code_t MODE_CODE_RLANE = 3'd4;
    localparam mode_code_t MODE_CODE_LTURN = 3'd5;
    localparam mode_code_t MODE_CODE_RTURN = 3'd6;

    localparam cfg_index_t CFG_CRUISE  = 3'd0;
    localparam cfg_index_t CFG_STOPPED = 3'd1;
    localparam cfg_index_t CFG_REVERSE = 3'd2;
    localparam cfg_index_t CFG_CENTER  = 3'd3;
    localparam cfg_index_t CFG_FLEFT   = 3'd4;
    localparam cfg_index_t CFG_FRIGHT  = 3'd5;
    localparam cfg_index_t CFG_NLEFT   = 3'd6;
    localparam cfg_index_t CFG_NRIGHT  = 3'd7;

    localparam pwm_t RST_CRUISE  = 10'd400;
    localparam pwm_t RST_STOPPED = 10'd370;
    localparam pwm_t RST_REVERSE = 10'd270;
    localparam pwm_t RST_CENTER  = 10'd360;
    localparam pwm_t RST_FLEFT   = 10'd455;
    localparam pwm_t RST_FRIGHT  = 10'd265;
    localparam pwm_t RST_NLEFT   = 10'd380;
    localparam pwm_t RST_NRIGHT  = 10'd340;
    localparam pwm_t RST_LAST_STEER = 10'd360;

    localparam hold_t HOLD_NONE  = 5'd0;
    localparam hold_t HOLD_SHORT = 5'd10;
    localparam hold_t HOLD_TURN  = 5'd12;
    localparam hold_t HOLD_LONG  = 5'd20;

    localparam logic [1:0] LANE_STEP_FIRST  = 2'd0;
    localparam logic [1:0] LANE_STEP_SECOND = 2'd1;
    localparam logic [1:0] LANE_STEP_THIRD  = 2'd2;
    localparam logic [1:0] LANE_STEP_FINISH = 2'd3;

    typedef enum logic [6:0] {
        MODE_READY = 7'b0000001,
        MODE_KEEP  = 7'b0000010,
        MODE_STOP  = 7'b0000100,
        MODE_LLANE = 7'b0001000,
        MODE_RLANE = 7'b0010000,
        MODE_LTURN = 7'b0100000,
        MODE_RTURN = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic command_valid;
        cmd_t command;
    } dcs_in_t;

    typedef struct packed {
        logic       publish;
        pwm_t       steer_out;
        pwm_t       throttle_out;
        hold_t      hold_tenths;
        mode_code_t mode_code;
    } dcs_out_t;

    function automatic mode_code_t mode_to_code(mode_t m);
        mode_code_t code;
        unique case (m)
            MODE_READY: code = MODE_CODE_READY;
            MODE_KEEP:  code = MODE_CODE_KEEP;
            MODE_STOP:  code = MODE_CODE_STOP;
            MODE_LLANE: code = MODE_CODE_LLANE;
            MODE_RLANE: code = MODE_CODE_RLANE;
            MODE_LTURN: code = MODE_CODE_LTURN;
            MODE_RTURN: code = MODE_CODE_RTURN;
            default:    code = MODE_CODE_READY;
        endcase
        return code;
    endfunction

endpackage

// ----- sv/drive_command_sequencer.sv -----
// Each result is registered in the output stage before it reaches m_data.
// Throughput: one input transfer per cycle while the skid entry is empty; a two-entry output stage keeps
// taking input while one result waits for the downstream side.
// Reset (aresetn, synchronous, active low) returns the mode to ready, clears the
// latched command and the step counters, and restores the default PWM registers.
`timescale 1ns / 1ps

module drive_command_sequencer import dcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dcs_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output dcs_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  pwm_t       cfg_wdata
);

    pwm_t cruise_reg, stopped_reg, reverse_reg, center_reg;
    pwm_t fleft_reg, fright_reg, nleft_reg, nright_reg;

    mode_t      mode_reg, mode_next;
    cmd_t       latched_reg, latched_next;
    pwm_t       last_steer_reg, last_steer_next;
    logic [1:0] rstep_reg, rstep_next;
    logic [1:0] lstep_reg, lstep_next;
    logic       stop_step_reg, stop_step_next;

    dcs_out_t main_reg, skid_reg;
    logic     main_valid_reg, skid_valid_reg;
    dcs_out_t result;

    logic in_xfer, out_xfer;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign m_valid   = main_valid_reg;
    assign m_data    = main_reg;
    assign in_xfer   = s_valid && s_ready;
    assign out_xfer  = main_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cruise_reg  <= RST_CRUISE;
            stopped_reg <= RST_STOPPED;
            reverse_reg <= RST_REVERSE;
            center_reg  <= RST_CENTER;
            fleft_reg   <= RST_FLEFT;
            fright_reg  <= RST_FRIGHT;
            nleft_reg   <= RST_NLEFT;
            nright_reg  <= RST_NRIGHT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CRUISE:  cruise_reg  <= cfg_wdata;
                CFG_STOPPED: stopped_reg <= cfg_wdata;
                CFG_REVERSE: reverse_reg <= cfg_wdata;
                CFG_CENTER:  center_reg  <= cfg_wdata;
                CFG_FLEFT:   fleft_reg   <= cfg_wdata;
                CFG_FRIGHT:  fright_reg  <= cfg_wdata;
                CFG_NLEFT:   nleft_reg   <= cfg_wdata;
                CFG_NRIGHT:  nright_reg  <= cfg_wdata;
                default:     cruise_reg  <= cruise_reg;
            endcase
        end
    end

    always_comb begin
        cmd_t       cmd;
        mode_t      target;
        mode_t      moved;
        logic [1:0] step;
        pwm_t       first_steer;
        pwm_t       third_steer;
        logic       lane_right;

        cmd = latched_reg;
        if (s_data.command_valid) begin
            cmd = s_data.command;
        end

        case (cmd)
            CMD_RLANE:  target = MODE_RLANE;
            CMD_LLANE:  target = MODE_LLANE;
            CMD_TRIGHT: target = MODE_RTURN;
            CMD_TLEFT:  target = MODE_LTURN;
            default:    target = mode_reg;
        endcase

        unique case (mode_reg)
            MODE_READY: moved = (cmd == CMD_KEEP) ? MODE_KEEP : MODE_READY;
            MODE_KEEP:  moved = (cmd == CMD_STOP) ? MODE_STOP : target;
            MODE_STOP:  moved = (cmd == CMD_KEEP) ? MODE_KEEP : target;
            default: begin
                if (cmd == CMD_KEEP) begin
                    moved = MODE_KEEP;
                end else if (cmd == CMD_STOP) begin
                    moved = MODE_STOP;
                end else begin
                    moved = mode_reg;
                end
            end
        endcase

        lane_right  = (moved == MODE_RLANE);
        step        = lane_right ? rstep_reg : lstep_reg;
        first_steer = lane_right ? fright_reg : fleft_reg;
        third_steer = lane_right ? fleft_reg : fright_reg;

        mode_next       = moved;
        latched_next    = cmd;
        last_steer_next = last_steer_reg;
        rstep_next      = rstep_reg;
        lstep_next      = lstep_reg;
        stop_step_next  = stop_step_reg;
        result.publish      = 1'b1;
        result.steer_out    = '0;
        result.throttle_out = '0;
        result.hold_tenths  = HOLD_NONE;

        unique case (moved)
            MODE_KEEP: begin
                result.throttle_out = cruise_reg;
                if (cmd == CMD_KLEFT) begin
                    result.steer_out = nleft_reg;
                end else if (cmd == CMD_KRIGHT) begin
                    result.steer_out = nright_reg;
                end else begin
                    result.steer_out = center_reg;
                end
            end
            MODE_STOP: begin
                result.hold_tenths = HOLD_SHORT;
                if (!stop_step_reg) begin
                    result.steer_out    = last_steer_reg;
                    result.throttle_out = reverse_reg;
                    stop_step_next      = 1'b1;
                end else begin
                    result.throttle_out = stopped_reg;
                    stop_step_next      = 1'b0;
                    mode_next           = MODE_READY;
                end
            end
            MODE_RLANE, MODE_LLANE: begin
                result.throttle_out = cruise_reg;
                case (step)
                    LANE_STEP_FIRST: begin
                        last_steer_next    = first_steer;
                        result.steer_out   = first_steer;
                        result.hold_tenths = HOLD_LONG;
                        step               = LANE_STEP_SECOND;
                    end
                    LANE_STEP_SECOND: begin
                        result.steer_out   = center_reg;
                        result.hold_tenths = HOLD_SHORT;
                        step               = LANE_STEP_THIRD;
                    end
                    LANE_STEP_THIRD: begin
                        result.steer_out   = third_steer;
                        result.hold_tenths = HOLD_LONG;
                        step               = LANE_STEP_FINISH;
                    end
                    default: begin
                        result.publish      = 1'b0;
                        result.throttle_out = '0;
                        mode_next           = MODE_KEEP;
                        latched_next        = CMD_KEEP;
                        step                = LANE_STEP_FIRST;
                    end
                endcase
                if (lane_right) begin
                    rstep_next = step;
                end else begin
                    lstep_next = step;
                end
            end
            MODE_RTURN, MODE_LTURN: begin
                result.steer_out    = (moved == MODE_RTURN) ? fright_reg : fleft_reg;
                result.throttle_out = cruise_reg;
                result.hold_tenths  = HOLD_TURN;
                mode_next           = MODE_KEEP;
                latched_next        = CMD_KEEP;
            end
            default: begin
                mode_next           = MODE_READY;
                last_steer_next     = center_reg;
                result.steer_out    = center_reg;
                result.throttle_out = stopped_reg;
            end
        endcase

        result.mode_code = mode_to_code(mode_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_READY;
            latched_reg    <= CMD_NONE;
            last_steer_reg <= RST_LAST_STEER;
            rstep_reg      <= LANE_STEP_FIRST;
            lstep_reg      <= LANE_STEP_FIRST;
            stop_step_reg  <= 1'b0;
        end else if (in_xfer) begin
            mode_reg       <= mode_next;
            latched_reg    <= latched_next;
            last_steer_reg <= last_steer_next;
            rstep_reg      <= rstep_next;
            lstep_reg      <= lstep_next;
            stop_step_reg  <= stop_step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_xfer) begin
            if (skid_valid_reg) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_xfer;
                if (in_xfer) begin
                    main_reg <= result;
                end
            end
        end else if (in_xfer) begin
            if (!main_valid_reg) begin
                main_reg       <= result;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

// ----- sv/dcs_checker.sv -----
// Port-level checks for the drive command sequencer, bound to the top level.
// Depends on dcs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcs_checker import dcs_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input dcs_out_t   m_data
);

    // A stalled result keeps its valid and its payload.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `ASSERT_CLK(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_data), "result changed while stalled")

    // A silent tick only happens when a lane change finishes into keep lane.
    `ASSERT_CLK(a_silent_tick, aclk, aresetn, m_valid && !m_data.publish |-> m_data.steer_out == '0 && m_data.throttle_out == '0 && m_data.hold_tenths == HOLD_NONE && m_data.mode_code == MODE_CODE_KEEP, "bad silent result")

    // A turn hold always leaves the vehicle in keep lane.
    `ASSERT_CLK(a_turn_keep, aclk, aresetn, m_valid && m_data.hold_tenths == HOLD_TURN |-> m_data.mode_code == MODE_CODE_KEEP, "turn did not return to keep lane")

    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind drive_command_sequencer dcs_checker u_dcs_checker (.*);
